// File: hw/rtl/sjf_pkg.sv
// Shared types, constants and state encodings of the segment junction finder.
package sjf_pkg;

  localparam int MAX_WIRES_DEF   = 64;
  localparam int COORD_WIDTH_DEF = 16;
  localparam int FIELD_WIDTH     = 16;
  localparam int INDEX_WIDTH     = 6;
  localparam int THRESH_WIDTH    = 32;
  localparam logic [THRESH_WIDTH-1:0] THRESH_RESET = 32'd655;
  localparam int QUEUE_DEPTH     = 4;

  typedef struct packed {
    logic                          clear_store;
    logic signed [FIELD_WIDTH-1:0] start_x;
    logic signed [FIELD_WIDTH-1:0] start_y;
    logic signed [FIELD_WIDTH-1:0] end_x;
    logic signed [FIELD_WIDTH-1:0] end_y;
  } segment_t;

  typedef struct packed {
    logic [INDEX_WIDTH-1:0]        older_index;
    logic [INDEX_WIDTH-1:0]        newer_index;
    logic signed [FIELD_WIDTH-1:0] cross_x;
    logic signed [FIELD_WIDTH-1:0] cross_y;
    logic                          last_junction;
    logic                          store_full;
  } result_t;

  typedef enum logic [1:0] {
    ENTRY_PAIR,
    ENTRY_END,
    ENTRY_FULL
  } entry_kind_t;

  typedef enum logic [2:0] {
    F_IDLE,
    F_SETUP,
    F_BN,
    F_READ,
    F_MULT,
    F_CLASS,
    F_END,
    F_FULL
  } front_state_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_MUL,
    B_DIV_SETUP,
    B_DIV,
    B_CHECK
  } back_state_t;

endpackage

// File: hw/rtl/sjf_queue.sv
// Small FIFO that carries classified wire pairs and end or full entries from the front to the back.
module sjf_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = sjf_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             full,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CNTW-1:0]  fill;

  assign full  = (fill == CNTW'(DEPTH));
  assign empty = (fill == '0);
  assign rdata = slots[rd_ptr];

  // Store an entry on push
  always_ff @(posedge clk) begin
    if (push && !full) begin
      slots[wr_ptr] <= wdata;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop && !empty) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({push && !full, pop && !empty})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

// File: hw/rtl/sjf_front.sv
// Front part: takes wires, keeps the wire store and screens out parallel pairs.
module sjf_front #(
  parameter int MAX_WIRES   = sjf_pkg::MAX_WIRES_DEF,
  parameter int COORD_WIDTH = sjf_pkg::COORD_WIDTH_DEF,
  parameter int QW          = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          accept,
  input  sjf_pkg::segment_t             segment,
  input  logic [sjf_pkg::THRESH_WIDTH-1:0] threshold,
  input  logic                          q_full,
  output logic                          q_push,
  output logic [QW-1:0]                 q_data,
  output logic signed [COORD_WIDTH-1:0] new_x0,
  output logic signed [COORD_WIDTH-1:0] new_y0,
  output logic signed [COORD_WIDTH-1:0] new_x1,
  output logic signed [COORD_WIDTH-1:0] new_y1,
  output logic signed [2*COORD_WIDTH:0] new_bn,
  output logic [$clog2(MAX_WIRES)-1:0]  new_index
);

  localparam int C    = COORD_WIDTH;
  localparam int IW   = $clog2(MAX_WIRES);
  localparam int CW   = $clog2(MAX_WIRES + 1);
  localparam int DW   = 2 * C + 3;
  localparam int AW   = 2 * C + 1;
  localparam int EXT  = (C > sjf_pkg::FIELD_WIDTH) ? C : sjf_pkg::FIELD_WIDTH;
  localparam int TW   = (DW > sjf_pkg::THRESH_WIDTH) ? DW : sjf_pkg::THRESH_WIDTH;

  sjf_pkg::front_state_t state, state_next;

  logic [4*C-1:0]        mem [MAX_WIRES];
  logic [4*C-1:0]        mem_q;
  logic                  mem_we;

  logic [CW-1:0]         count;
  logic [CW-1:0]         idx;
  logic [CW-1:0]         count_eff;
  logic signed [C:0]     dxn;
  logic signed [C:0]     dyn;
  logic signed [2*C+1:0] p1;
  logic signed [2*C+1:0] p2;
  logic signed [2*C-1:0] p3;
  logic signed [2*C-1:0] p4;

  logic [EXT-1:0]        ext_x0, ext_y0, ext_x1, ext_y1;
  logic signed [C-1:0]   in_x0, in_y0, in_x1, in_y1;
  logic signed [C-1:0]   o_x0, o_y0, o_x1, o_y1;
  logic signed [C:0]     dxo, dyo;
  logic signed [C-1:0]   ma, mb, mc, md;
  logic signed [DW-1:0]  det;
  logic signed [AW-1:0]  ao;
  logic [DW-1:0]         det_mag;
  logic                  non_parallel;
  logic                  last_pair;
  sjf_pkg::entry_kind_t  kind;

  // Take the low coordinate bits of each field
  always_comb begin
    ext_x0 = EXT'($unsigned(segment.start_x));
    ext_y0 = EXT'($unsigned(segment.start_y));
    ext_x1 = EXT'($unsigned(segment.end_x));
    ext_y1 = EXT'($unsigned(segment.end_y));
    in_x0  = signed'(ext_x0[C-1:0]);
    in_y0  = signed'(ext_y0[C-1:0]);
    in_x1  = signed'(ext_x1[C-1:0]);
    in_y1  = signed'(ext_y1[C-1:0]);
  end

  assign count_eff = segment.clear_store ? '0 : count;

  // Unpack the stored wire and classify the pair
  always_comb begin
    {o_x0, o_y0, o_x1, o_y1} = mem_q;
    dxo          = (C+1)'(o_x0) - (C+1)'(o_x1);
    dyo          = (C+1)'(o_y0) - (C+1)'(o_y1);
    det          = DW'(p1) - DW'(p2);
    ao           = AW'(p3) - AW'(p4);
    det_mag      = det[DW-1] ? DW'(-det) : DW'(det);
    non_parallel = (det != '0) && (TW'(det_mag) >= TW'(threshold));
    last_pair    = (idx == count - 1'b1);
  end

  // Share the endpoint multipliers between the new wire and stored wires
  always_comb begin
    if (state == sjf_pkg::F_SETUP) begin
      ma = new_x0;
      mb = new_y1;
      mc = new_y0;
      md = new_x1;
    end else begin
      ma = o_x0;
      mb = o_y1;
      mc = o_y0;
      md = o_x1;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      sjf_pkg::F_IDLE: begin
        if (accept) begin
          state_next = (count_eff == CW'(MAX_WIRES)) ? sjf_pkg::F_FULL : sjf_pkg::F_SETUP;
        end
      end
      sjf_pkg::F_SETUP: state_next = sjf_pkg::F_BN;
      sjf_pkg::F_BN:    state_next = (count == '0) ? sjf_pkg::F_END : sjf_pkg::F_READ;
      sjf_pkg::F_READ:  state_next = sjf_pkg::F_MULT;
      sjf_pkg::F_MULT:  state_next = sjf_pkg::F_CLASS;
      sjf_pkg::F_CLASS: begin
        if (!non_parallel || !q_full) begin
          state_next = last_pair ? sjf_pkg::F_END : sjf_pkg::F_READ;
        end
      end
      sjf_pkg::F_END: begin
        if (!q_full) begin
          state_next = sjf_pkg::F_IDLE;
        end
      end
      sjf_pkg::F_FULL: begin
        if (!q_full) begin
          state_next = sjf_pkg::F_IDLE;
        end
      end
      default: state_next = sjf_pkg::F_IDLE;
    endcase
  end

  // Queue pushes and store writes
  always_comb begin
    q_push = 1'b0;
    mem_we = 1'b0;
    kind   = sjf_pkg::ENTRY_PAIR;
    unique case (state)
      sjf_pkg::F_CLASS: begin
        q_push = non_parallel && !q_full;
      end
      sjf_pkg::F_END: begin
        kind   = sjf_pkg::ENTRY_END;
        q_push = !q_full;
        mem_we = !q_full;
      end
      sjf_pkg::F_FULL: begin
        kind   = sjf_pkg::ENTRY_FULL;
        q_push = !q_full;
      end
      default: begin
        q_push = 1'b0;
      end
    endcase
    q_data = {kind, idx[IW-1:0], o_x0, o_y0, o_x1, o_y1, det, ao};
  end

  // Wire store
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[count[IW-1:0]] <= {new_x0, new_y0, new_x1, new_y1};
    end
    mem_q <= mem[idx[IW-1:0]];
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sjf_pkg::F_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      if (state == sjf_pkg::F_IDLE && accept) begin
        count <= count_eff;
      end else if (mem_we) begin
        count <= count + 1'b1;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    unique case (state)
      sjf_pkg::F_IDLE: begin
        if (accept) begin
          new_x0    <= in_x0;
          new_y0    <= in_y0;
          new_x1    <= in_x1;
          new_y1    <= in_y1;
          new_index <= count_eff[IW-1:0];
          idx       <= '0;
        end
      end
      sjf_pkg::F_SETUP: begin
        p3  <= ma * mb;
        p4  <= mc * md;
        dxn <= (C+1)'(new_x0) - (C+1)'(new_x1);
        dyn <= (C+1)'(new_y0) - (C+1)'(new_y1);
      end
      sjf_pkg::F_BN: begin
        new_bn <= AW'(p3) - AW'(p4);
      end
      sjf_pkg::F_MULT: begin
        p1 <= dxo * dyn;
        p2 <= dyo * dxn;
        p3 <= ma * mb;
        p4 <= mc * md;
      end
      sjf_pkg::F_CLASS: begin
        if (!non_parallel || !q_full) begin
          idx <= idx + 1'b1;
        end
      end
      default: begin
        idx <= idx;
      end
    endcase
  end

endmodule

// File: hw/rtl/sjf_back.sv
// Back part: serial multiply and divide per pair, box test and result output.
module sjf_back #(
  parameter int MAX_WIRES   = sjf_pkg::MAX_WIRES_DEF,
  parameter int COORD_WIDTH = sjf_pkg::COORD_WIDTH_DEF,
  parameter int QW          = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_empty,
  input  logic [QW-1:0]                 q_data,
  output logic                          q_pop,
  input  logic signed [COORD_WIDTH-1:0] new_x0,
  input  logic signed [COORD_WIDTH-1:0] new_y0,
  input  logic signed [COORD_WIDTH-1:0] new_x1,
  input  logic signed [COORD_WIDTH-1:0] new_y1,
  input  logic signed [2*COORD_WIDTH:0] new_bn,
  input  logic [$clog2(MAX_WIRES)-1:0]  new_index,
  output sjf_pkg::result_t              result,
  output logic                          result_valid,
  output logic                          done
);

  localparam int C    = COORD_WIDTH;
  localparam int IW   = $clog2(MAX_WIRES);
  localparam int DW   = 2 * C + 3;
  localparam int AW   = 2 * C + 1;
  localparam int NW   = 3 * C + 3;
  localparam int RW   = NW + 1;
  localparam int QTW  = C + 1;
  localparam int XW   = C + 2;
  localparam int KW   = $clog2(C + 2);
  localparam int OW   = sjf_pkg::FIELD_WIDTH;
  localparam int EW   = (XW > OW) ? XW : OW;
  localparam int P_DET  = AW;
  localparam int P_Y1   = P_DET + DW;
  localparam int P_X1   = P_Y1 + C;
  localparam int P_Y0   = P_X1 + C;
  localparam int P_X0   = P_Y0 + C;
  localparam int P_IDX  = P_X0 + C;
  localparam int P_KIND = P_IDX + IW;

  sjf_pkg::back_state_t state, state_next;

  // Head of queue fields
  sjf_pkg::entry_kind_t  h_kind;
  logic [IW-1:0]         h_idx;
  logic signed [C-1:0]   h_x0, h_y0, h_x1, h_y1;
  logic signed [DW-1:0]  h_det;
  logic signed [AW-1:0]  h_ao;

  // Pair registers
  logic signed [C-1:0]   o_x0, o_y0, o_x1, o_y1;
  logic signed [DW-1:0]  det_r;
  logic [IW-1:0]         oidx;
  logic signed [NW-1:0]  mcand;
  logic [C:0]            mx, my;
  logic signed [NW-1:0]  accx, accy;
  logic [KW-1:0]         k;
  logic                  phase;
  logic [RW-1:0]         rx, ry, dsh;
  logic [QTW-1:0]        qx, qy;
  logic                  negx, negy, ovfx, ovfy;

  // Pending result, held until the next one or the end of the wire
  logic                  pend_valid;
  logic [IW-1:0]         pend_idx;
  logic signed [OW-1:0]  pend_x, pend_y;

  logic                  sub;
  logic signed [NW-1:0]  termx, termy;
  logic signed [C:0]     dxn, dyn, dxo, dyo;
  logic [NW-1:0]         nx_mag, ny_mag;
  logic [DW-1:0]         d_mag;
  logic signed [XW-1:0]  x, y;
  logic signed [EW-1:0]  xe, ye;
  logic                  hit;
  logic                  last_step;

  function automatic logic in_range(input logic signed [XW-1:0] v,
                                    input logic signed [XW-1:0] a,
                                    input logic signed [XW-1:0] b);
    logic signed [XW-1:0] lo;
    logic signed [XW-1:0] hi;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    return (lo <= v) && (v <= hi);
  endfunction

  // Unpack the queue head
  always_comb begin
    h_kind = sjf_pkg::entry_kind_t'(q_data[P_KIND +: 2]);
    h_idx  = q_data[P_IDX +: IW];
    h_x0   = signed'(q_data[P_X0 +: C]);
    h_y0   = signed'(q_data[P_Y0 +: C]);
    h_x1   = signed'(q_data[P_X1 +: C]);
    h_y1   = signed'(q_data[P_Y1 +: C]);
    h_det  = signed'(q_data[P_DET +: DW]);
    h_ao   = signed'(q_data[AW-1:0]);
  end

  // Arithmetic terms
  always_comb begin
    dxn       = (C+1)'(new_x0) - (C+1)'(new_x1);
    dyn       = (C+1)'(new_y0) - (C+1)'(new_y1);
    dxo       = (C+1)'(o_x0) - (C+1)'(o_x1);
    dyo       = (C+1)'(o_y0) - (C+1)'(o_y1);
    last_step = (k == KW'(C));
    sub       = phase ^ last_step;
    termx     = mx[0] ? mcand : '0;
    termy     = my[0] ? mcand : '0;
    nx_mag    = accx[NW-1] ? NW'(-accx) : NW'(accx);
    ny_mag    = accy[NW-1] ? NW'(-accy) : NW'(accy);
    d_mag     = det_r[DW-1] ? DW'(-det_r) : DW'(det_r);
    x         = negx ? -signed'(XW'(qx)) : signed'(XW'(qx));
    y         = negy ? -signed'(XW'(qy)) : signed'(XW'(qy));
    xe        = EW'(x);
    ye        = EW'(y);
    hit       = !ovfx && !ovfy &&
                in_range(x, XW'(o_x0), XW'(o_x1)) && in_range(x, XW'(new_x0), XW'(new_x1)) &&
                in_range(y, XW'(o_y0), XW'(o_y1)) && in_range(y, XW'(new_y0), XW'(new_y1));
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      sjf_pkg::B_IDLE: begin
        if (!q_empty && h_kind == sjf_pkg::ENTRY_PAIR) begin
          state_next = sjf_pkg::B_MUL;
        end
      end
      sjf_pkg::B_MUL: begin
        if (last_step && phase) begin
          state_next = sjf_pkg::B_DIV_SETUP;
        end
      end
      sjf_pkg::B_DIV_SETUP: state_next = sjf_pkg::B_DIV;
      sjf_pkg::B_DIV: begin
        if (last_step) begin
          state_next = sjf_pkg::B_CHECK;
        end
      end
      sjf_pkg::B_CHECK: state_next = sjf_pkg::B_IDLE;
      default:          state_next = sjf_pkg::B_IDLE;
    endcase
  end

  // Queue pop and end of wire
  always_comb begin
    q_pop = 1'b0;
    done  = 1'b0;
    if (state == sjf_pkg::B_IDLE && !q_empty) begin
      q_pop = 1'b1;
      done  = (h_kind != sjf_pkg::ENTRY_PAIR);
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= sjf_pkg::B_IDLE;
      pend_valid   <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= 1'b0;
      if (state == sjf_pkg::B_IDLE && !q_empty && h_kind != sjf_pkg::ENTRY_PAIR) begin
        result_valid <= (h_kind == sjf_pkg::ENTRY_FULL) || pend_valid;
        pend_valid   <= 1'b0;
      end else if (state == sjf_pkg::B_CHECK && hit) begin
        result_valid <= pend_valid;
        pend_valid   <= 1'b1;
      end
    end
  end

  // Result register and pending junction
  always_ff @(posedge clk) begin
    if (state == sjf_pkg::B_IDLE && !q_empty && h_kind != sjf_pkg::ENTRY_PAIR) begin
      if (h_kind == sjf_pkg::ENTRY_FULL) begin
        result.older_index   <= '0;
        result.newer_index   <= '0;
        result.cross_x       <= '0;
        result.cross_y       <= '0;
        result.last_junction <= 1'b0;
        result.store_full    <= 1'b1;
      end else begin
        result.older_index   <= sjf_pkg::INDEX_WIDTH'(pend_idx);
        result.newer_index   <= sjf_pkg::INDEX_WIDTH'(new_index);
        result.cross_x       <= pend_x;
        result.cross_y       <= pend_y;
        result.last_junction <= 1'b1;
        result.store_full    <= 1'b0;
      end
    end else if (state == sjf_pkg::B_CHECK && hit) begin
      result.older_index   <= sjf_pkg::INDEX_WIDTH'(pend_idx);
      result.newer_index   <= sjf_pkg::INDEX_WIDTH'(new_index);
      result.cross_x       <= pend_x;
      result.cross_y       <= pend_y;
      result.last_junction <= 1'b0;
      result.store_full    <= 1'b0;
      pend_idx             <= oidx;
      pend_x               <= xe[OW-1:0];
      pend_y               <= ye[OW-1:0];
    end
  end

  // Serial multiply and divide datapath
  always_ff @(posedge clk) begin
    unique case (state)
      sjf_pkg::B_IDLE: begin
        if (!q_empty && h_kind == sjf_pkg::ENTRY_PAIR) begin
          o_x0  <= h_x0;
          o_y0  <= h_y0;
          o_x1  <= h_x1;
          o_y1  <= h_y1;
          det_r <= h_det;
          oidx  <= h_idx;
          mcand <= NW'(h_ao);
          mx    <= dxn;
          my    <= dyn;
          accx  <= '0;
          accy  <= '0;
          k     <= '0;
          phase <= 1'b0;
        end
      end
      sjf_pkg::B_MUL: begin
        accx <= sub ? accx - termx : accx + termx;
        accy <= sub ? accy - termy : accy + termy;
        if (last_step) begin
          mcand <= NW'(new_bn);
          mx    <= dxo;
          my    <= dyo;
          k     <= '0;
          phase <= 1'b1;
        end else begin
          mcand <= mcand << 1;
          mx    <= mx >> 1;
          my    <= my >> 1;
          k     <= k + 1'b1;
        end
      end
      sjf_pkg::B_DIV_SETUP: begin
        negx <= accx[NW-1] ^ det_r[DW-1];
        negy <= accy[NW-1] ^ det_r[DW-1];
        ovfx <= RW'(nx_mag) >= (RW'(d_mag) << (C + 1));
        ovfy <= RW'(ny_mag) >= (RW'(d_mag) << (C + 1));
        rx   <= RW'(nx_mag);
        ry   <= RW'(ny_mag);
        dsh  <= RW'(d_mag) << C;
        qx   <= '0;
        qy   <= '0;
        k    <= '0;
      end
      sjf_pkg::B_DIV: begin
        if (rx >= dsh) begin
          rx <= rx - dsh;
          qx <= {qx[QTW-2:0], 1'b1};
        end else begin
          qx <= {qx[QTW-2:0], 1'b0};
        end
        if (ry >= dsh) begin
          ry <= ry - dsh;
          qy <= {qy[QTW-2:0], 1'b1};
        end else begin
          qy <= {qy[QTW-2:0], 1'b0};
        end
        dsh <= dsh >> 1;
        k   <= k + 1'b1;
      end
      default: begin
        k <= k;
      end
    endcase
  end

endmodule

// File: hw/rtl/segment_junction_finder.sv
// Top level of the segment junction finder: registers, handshake and sub-blocks.
//
//  channel    | ports                                   | transfer
//  -----------+-----------------------------------------+-------------------------------
//  wire in    | start, busy, segment                    | start high and busy low
//  result out | result_valid, result                    | every cycle result_valid is high
//  threshold  | threshold_write, threshold_data         | every cycle threshold_write is high
//
// With no non-parallel pair, busy stays high while the front steps through F_SETUP and F_BN,
// then F_READ, F_MULT and F_CLASS for each of the N stored wires, and F_END; a wire that finds
// the store full holds it only through F_FULL. Each non-parallel pair goes through a serial
// multiply-accumulate and restoring divide in the back, which runs beside the front; with many
// such pairs the back sets the time and the front stalls on the four-entry queue.
// Reset clears the wire count and loads the default threshold; stored wires are read only
// after write.
// Results cannot be held off; busy drops in the cycle that shows the last result of a wire.
module segment_junction_finder #(
  parameter int MAX_WIRES   = sjf_pkg::MAX_WIRES_DEF,
  parameter int COORD_WIDTH = sjf_pkg::COORD_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  sjf_pkg::segment_t                segment,
  output logic                             result_valid,
  output sjf_pkg::result_t                 result,
  input  logic                             threshold_write,
  input  logic [sjf_pkg::THRESH_WIDTH-1:0] threshold_data
);

  localparam int C  = COORD_WIDTH;
  localparam int IW = $clog2(MAX_WIRES);
  localparam int QW = 2 + IW + 4 * C + (2 * C + 3) + (2 * C + 1);

  logic [sjf_pkg::THRESH_WIDTH-1:0] threshold;
  logic                             accept;
  logic                             q_push, q_pop, q_full, q_empty;
  logic [QW-1:0]                    q_wdata, q_rdata;
  logic signed [C-1:0]              new_x0, new_y0, new_x1, new_y1;
  logic signed [2*C:0]              new_bn;
  logic [IW-1:0]                    new_index;
  logic                             done;

  assign accept = start && !busy;

  // Hold the threshold register and the busy flag
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= sjf_pkg::THRESH_RESET;
      busy      <= 1'b0;
    end else begin
      if (threshold_write) begin
        threshold <= threshold_data;
      end
      if (accept) begin
        busy <= 1'b1;
      end else if (done) begin
        busy <= 1'b0;
      end
    end
  end

  sjf_front #(
    .MAX_WIRES  (MAX_WIRES),
    .COORD_WIDTH(COORD_WIDTH),
    .QW         (QW)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .segment   (segment),
    .threshold (threshold),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (q_wdata),
    .new_x0    (new_x0),
    .new_y0    (new_y0),
    .new_x1    (new_x1),
    .new_y1    (new_y1),
    .new_bn    (new_bn),
    .new_index (new_index)
  );

  sjf_queue #(
    .WIDTH(QW),
    .DEPTH(sjf_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (q_push),
    .wdata(q_wdata),
    .pop  (q_pop),
    .rdata(q_rdata),
    .full (q_full),
    .empty(q_empty)
  );

  sjf_back #(
    .MAX_WIRES  (MAX_WIRES),
    .COORD_WIDTH(COORD_WIDTH),
    .QW         (QW)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_empty     (q_empty),
    .q_data      (q_rdata),
    .q_pop       (q_pop),
    .new_x0      (new_x0),
    .new_y0      (new_y0),
    .new_x1      (new_x1),
    .new_y1      (new_y1),
    .new_bn      (new_bn),
    .new_index   (new_index),
    .result      (result),
    .result_valid(result_valid),
    .done        (done)
  );

endmodule

// File: hw/rtl/sjf_checker.sv
// Port-level checks of the segment junction finder, bound to the top level.
module sjf_checker (
  input logic             clk,
  input logic             rst,
  input logic             start,
  input logic             busy,
  input logic             result_valid,
  input sjf_pkg::result_t result
);

  // A dropped wire reports nothing but the full flag
  a_full_clean: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.store_full |->
      result.older_index == '0 && result.newer_index == '0 &&
      result.cross_x == '0 && result.cross_y == '0 && !result.last_junction)
    else $error("full result carries junction data");

  // A junction pairs a stored wire with a newer one
  a_index_order: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.store_full |-> result.older_index < result.newer_index)
    else $error("older index not below newer index");

  // A transfer makes the block busy
  a_busy_after_start: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("busy not raised after transfer");

endmodule

bind segment_junction_finder sjf_checker u_sjf_checker (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .result_valid(result_valid),
  .result      (result)
);

// File: verif/segment_junction_finder_test.sv
// Self-checking testbench of the segment junction finder: directed and random wires.
`timescale 1ns / 1ps

module segment_junction_finder_test;

  localparam int STORE_DEPTH = sjf_pkg::MAX_WIRES_DEF;
  localparam longint QUOT_LIMIT = 64'sd1 << 40;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  sjf_pkg::segment_t segment;
  logic result_valid;
  sjf_pkg::result_t result;
  logic threshold_write;
  logic [sjf_pkg::THRESH_WIDTH-1:0] threshold_data;

  // Predictor state
  longint sx0[STORE_DEPTH];
  longint sy0[STORE_DEPTH];
  longint sx1[STORE_DEPTH];
  longint sy1[STORE_DEPTH];
  int stored_wires;
  logic [sjf_pkg::THRESH_WIDTH-1:0] model_threshold;
  sjf_pkg::result_t junction_queue[$];

  int mismatches;
  int burst_left;

  segment_junction_finder dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .segment(segment),
    .result_valid(result_valid),
    .result(result),
    .threshold_write(threshold_write),
    .threshold_data(threshold_data)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // (p*q - r*s) / d truncated toward zero, magnitude clamped
  function automatic longint junction_coord(longint p, longint q, longint r, longint s,
                                            longint d);
    logic signed [127:0] a;
    logic signed [127:0] b;
    logic signed [127:0] num;
    logic signed [127:0] den;
    logic signed [127:0] qt;
    a = p;
    b = r;
    num = a * q - b * s;
    den = d;
    qt = num / den;
    if (qt > QUOT_LIMIT) qt = QUOT_LIMIT;
    if (qt < -QUOT_LIMIT) qt = -QUOT_LIMIT;
    return longint'(qt);
  endfunction

  function automatic bit between(longint v, longint a, longint b);
    longint lo;
    longint hi;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    return (lo <= v) && (v <= hi);
  endfunction

  // Work out the junctions of one accepted wire and store it unless the store is full
  task automatic predict_junctions(sjf_pkg::segment_t w);
    longint x0, y0, x1, y1, dxn, dyn, bn, dxo, dyo, det, ao, x, y, mag;
    sjf_pkg::result_t r;
    int n;
    n = 0;
    if (w.clear_store) stored_wires = 0;
    if (stored_wires >= STORE_DEPTH) begin
      r = '0;
      r.store_full = 1'b1;
      junction_queue.push_back(r);
      return;
    end
    x0 = longint'(w.start_x);
    y0 = longint'(w.start_y);
    x1 = longint'(w.end_x);
    y1 = longint'(w.end_y);
    dxn = x0 - x1;
    dyn = y0 - y1;
    bn = x0 * y1 - y0 * x1;
    for (int i = 0; i < stored_wires; i++) begin
      dxo = sx0[i] - sx1[i];
      dyo = sy0[i] - sy1[i];
      det = dxo * dyn - dyo * dxn;
      mag = (det < 0) ? -det : det;
      if (det == 0 || mag < longint'({32'd0, model_threshold})) continue;
      ao = sx0[i] * sy1[i] - sy0[i] * sx1[i];
      x = junction_coord(ao, dxn, bn, dxo, det);
      y = junction_coord(ao, dyn, bn, dyo, det);
      if (!(between(x, sx0[i], sx1[i]) && between(x, x0, x1) &&
            between(y, sy0[i], sy1[i]) && between(y, y0, y1))) continue;
      r = '0;
      r.older_index = i[sjf_pkg::INDEX_WIDTH-1:0];
      r.newer_index = stored_wires[sjf_pkg::INDEX_WIDTH-1:0];
      r.cross_x = x[sjf_pkg::FIELD_WIDTH-1:0];
      r.cross_y = y[sjf_pkg::FIELD_WIDTH-1:0];
      junction_queue.push_back(r);
      n++;
    end
    // Mark the final junction of this wire
    if (n > 0) begin
      r = junction_queue.pop_back();
      r.last_junction = 1'b1;
      junction_queue.push_back(r);
    end
    sx0[stored_wires] = x0;
    sy0[stored_wires] = y0;
    sx1[stored_wires] = x1;
    sy1[stored_wires] = y1;
    stored_wires++;
  endtask

  function automatic sjf_pkg::segment_t make_wire(bit first, int x0, int y0, int x1, int y1);
    sjf_pkg::segment_t w;
    w.clear_store = first;
    w.start_x = x0[sjf_pkg::FIELD_WIDTH-1:0];
    w.start_y = y0[sjf_pkg::FIELD_WIDTH-1:0];
    w.end_x = x1[sjf_pkg::FIELD_WIDTH-1:0];
    w.end_y = y1[sjf_pkg::FIELD_WIDTH-1:0];
    return w;
  endfunction

  // Transfer one wire; keep start high only when the burst goes on
  task automatic send_wire(sjf_pkg::segment_t w);
    int gap;
    @(negedge clk);
    start = 1'b1;
    segment = w;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_junctions(w);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(0, 6);
      @(negedge clk);
      start = 1'b0;
      repeat (gap) @(negedge clk);
      burst_left = $urandom_range(0, 7);
    end
  endtask

  // Drop start and wait until the block has gone quiet
  task automatic drain;
    @(negedge clk);
    start = 1'b0;
    while (junction_queue.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    while (busy) @(negedge clk);
  endtask

  task automatic set_threshold(logic [sjf_pkg::THRESH_WIDTH-1:0] value);
    drain();
    threshold_write = 1'b1;
    threshold_data = value;
    @(negedge clk);
    threshold_write = 1'b0;
    model_threshold = value;
  endtask

  function automatic sjf_pkg::segment_t random_wire(bit first, int span);
    return make_wire(first, $urandom_range(0, 2 * span) - span,
                     $urandom_range(0, 2 * span) - span,
                     $urandom_range(0, 2 * span) - span,
                     $urandom_range(0, 2 * span) - span);
  endfunction

  task automatic test_extremes;
    set_threshold(sjf_pkg::THRESH_RESET);
    send_wire(make_wire(1, -32768, -32768, 32767, 32767));
    send_wire(make_wire(0, -32768, 32767, 32767, -32768));
    // identical wire: zero determinant
    send_wire(make_wire(0, -32768, -32768, 32767, 32767));
    // point wire
    send_wire(make_wire(0, 0, 0, 0, 0));
    send_wire(make_wire(0, 100, -200, -100, 200));
    send_wire(make_wire(0, 32767, 0, -32768, 0));
    set_threshold('0);
    send_wire(make_wire(1, 0, 0, 256, 256));
    send_wire(make_wire(0, 0, 0, 256, 256));
    send_wire(make_wire(0, 0, 256, 256, 0));
    send_wire(make_wire(0, 1, 0, 0, 1));
    set_threshold('1);
    send_wire(make_wire(0, -32768, 0, 32767, 1));
    send_wire(make_wire(0, 0, -32768, 1, 32767));
  endtask

  // Fill the store with parallel wires, overflow it, then clear it
  task automatic test_full_store;
    set_threshold(sjf_pkg::THRESH_RESET);
    send_wire(make_wire(1, -1000, 0, 1000, 0));
    for (int i = 1; i < STORE_DEPTH; i++)
      send_wire(make_wire(0, -1000, i * 16, 1000, i * 16));
    send_wire(make_wire(0, 0, -2000, 0, 2000));
    send_wire(make_wire(0, 5, 5, 6, 6));
    send_wire(make_wire(1, 0, -2000, 0, 2000));
  endtask

  task automatic test_random_groups;
    int group_len;
    int span;
    logic [sjf_pkg::THRESH_WIDTH-1:0] settings[4];
    settings[0] = 0;
    settings[1] = sjf_pkg::THRESH_RESET;
    settings[2] = $urandom;
    settings[3] = '1;
    for (int phase = 0; phase < 5; phase++) begin
      if (phase == 4) set_threshold($urandom_range(0, 65536));
      else set_threshold(settings[phase]);
      for (int g = 0; g < 6; g++) begin
        group_len = $urandom_range(3, 12);
        span = ($urandom_range(0, 3) == 0) ? 32767 : $urandom_range(64, 3000);
        send_wire(random_wire(1, span));
        for (int k = 1; k < group_len; k++) begin
          // occasional noise: full range and stray clear flags
          if ($urandom_range(0, 9) == 0)
            send_wire(random_wire(1'($urandom_range(0, 1)), 32767));
          else send_wire(random_wire(0, span));
        end
      end
    end
  endtask

  // Compare each result with the oldest expected junction
  always @(posedge clk) begin
    if (!rst && result_valid) begin
      if (junction_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result %p", result);
      end else begin
        if (result !== junction_queue[0]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: expected %p actual %p", junction_queue[0], result);
        end
        void'(junction_queue.pop_front());
      end
    end
  end

  initial begin
    #200ms;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    rst = 1'b1;
    start = 1'b0;
    segment = '0;
    threshold_write = 1'b0;
    threshold_data = '0;
    stored_wires = 0;
    model_threshold = sjf_pkg::THRESH_RESET;
    mismatches = 0;
    burst_left = 0;
    repeat (2) @(negedge clk);
    rst = 1'b0;
    test_extremes();
    test_full_store();
    test_random_groups();
    drain();
    repeat (200) @(negedge clk);
    if (mismatches == 0 && junction_queue.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/sjf_pkg.sv
hw/rtl/sjf_queue.sv
hw/rtl/sjf_front.sv
hw/rtl/sjf_back.sv
hw/rtl/segment_junction_finder.sv
hw/rtl/sjf_checker.sv
verif/segment_junction_finder_test.sv
